@@ src/rfca_pkg.sv @@
package rfca_pkg;

	localparam int CNT_W = 9;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic [7:0] SC_RDM = 8'hCC;
	localparam logic [7:0] SC_SUB = 8'h01;
	localparam logic [7:0] RESP_MSG_LEN = 8'd24;
	localparam logic [7:0] CMD_GET_RESP = 8'h21;
	localparam logic [15:0] PID_SUPPORTED = 16'h0050;
	localparam logic [CNT_W-1:0] MIN_FRAME_LEN = 9'd5;

	// request byte positions (first byte after break is 1)
	localparam logic [CNT_W-1:0] POS_START = 9'd1;
	localparam logic [CNT_W-1:0] POS_SUB = 9'd2;
	localparam logic [CNT_W-1:0] POS_LEN = 9'd3;
	localparam int POS_DST = 4;
	localparam int POS_SRC = 10;
	localparam logic [CNT_W-1:0] POS_TID = 9'd16;
	localparam int UID_BYTES = 6;

	// response byte positions
	localparam int RESP_LEN = 26;
	localparam int IDX_W = $clog2(RESP_LEN);
	localparam logic [IDX_W-1:0] IDX_CSUM_HI = IDX_W'(RESP_LEN - 2);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RESP_LEN - 1);
	localparam int RIDX_SRC = 3;
	localparam int RIDX_DST = 9;
	localparam logic [IDX_W-1:0] RIDX_START = 5'd0;
	localparam logic [IDX_W-1:0] RIDX_SUB = 5'd1;
	localparam logic [IDX_W-1:0] RIDX_LEN = 5'd2;
	localparam logic [IDX_W-1:0] RIDX_TID = 5'd15;
	localparam logic [IDX_W-1:0] RIDX_CMD = 5'd20;
	localparam logic [IDX_W-1:0] RIDX_PID_HI = 5'd21;
	localparam logic [IDX_W-1:0] RIDX_PID_LO = 5'd22;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [47:0] src_uid;
		logic [47:0] dst_uid;
		logic [7:0]  tid;
	} resp_job_t;

	// body byte of the response, positions 0..23 (checksum handled elsewhere)
	function automatic logic [7:0] resp_byte(input resp_job_t job, input logic [IDX_W-1:0] idx);
		logic [7:0] r;
		r = 8'h00;
		unique case (idx)
			RIDX_START:  r = SC_RDM;
			RIDX_SUB:    r = SC_SUB;
			RIDX_LEN:    r = RESP_MSG_LEN;
			RIDX_TID:    r = job.tid;
			RIDX_CMD:    r = CMD_GET_RESP;
			RIDX_PID_HI: r = PID_SUPPORTED[15:8];
			RIDX_PID_LO: r = PID_SUPPORTED[7:0];
			default:     r = 8'h00;
		endcase
		for (int i = 0; i < UID_BYTES; i++) begin
			if (idx == IDX_W'(RIDX_SRC + i))
				r = job.src_uid[8*(UID_BYTES-1-i) +: 8];
			if (idx == IDX_W'(RIDX_DST + i))
				r = job.dst_uid[8*(UID_BYTES-1-i) +: 8];
		end
		return r;
	endfunction

endpackage

@@ src/rfca_in_if.sv @@
interface rfca_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

@@ src/rfca_out_if.sv @@
interface rfca_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       tx_last;

	modport source (output valid, output tx_byte, output tx_last, input ready);
	modport sink (input valid, input tx_byte, input tx_last, output ready);
endinterface

@@ src/rfca_front.sv @@
module rfca_front
	import rfca_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	rfca_in_if.sink    rx,
	input  logic       q_full,
	output logic       q_push,
	output resp_job_t  q_job
);

	logic             ok_q, ok_n;
	logic [CNT_W-1:0] cnt_q, cnt_n;
	logic             lk_q, lk_n;
	logic [CNT_W-1:0] flen_q, flen_n;
	resp_job_t        cap_q, cap_n;
	logic             acc, active;

	assign rx.ready = !q_full;
	assign acc = rx.valid && rx.ready;
	assign active = rx.frame_start || ok_q;

	always_comb begin
		ok_n = ok_q;
		cnt_n = cnt_q;
		lk_n = lk_q;
		flen_n = flen_q;
		cap_n = cap_q;
		if (rx.frame_start) begin
			ok_n = 1'b1;
			cnt_n = POS_START;
			lk_n = 1'b0;
			flen_n = '0;
			cap_n = '0;
		end else if (ok_q && cnt_q != CNT_MAX) begin
			cnt_n = cnt_q + 1'b1;
		end
		if (active) begin
			if (cnt_n == POS_START) begin
				if (rx.rx_byte != SC_RDM) ok_n = 1'b0;
			end else if (cnt_n == POS_SUB) begin
				if (rx.rx_byte != SC_SUB) ok_n = 1'b0;
			end else if (cnt_n == POS_LEN) begin
				flen_n = {1'b0, rx.rx_byte} + 9'd2;
				lk_n = 1'b1;
				if (flen_n < MIN_FRAME_LEN) ok_n = 1'b0;
			end else if (cnt_n == POS_TID) begin
				cap_n.tid = rx.rx_byte;
			end
			// UID bytes land at their own position so short frames read zero elsewhere
			for (int i = 0; i < UID_BYTES; i++) begin
				if (cnt_n == CNT_W'(POS_DST + i))
					cap_n.dst_uid[8*(UID_BYTES-1-i) +: 8] = rx.rx_byte;
				if (cnt_n == CNT_W'(POS_SRC + i))
					cap_n.src_uid[8*(UID_BYTES-1-i) +: 8] = rx.rx_byte;
			end
		end
	end

	assign q_push = acc && active && ok_n && lk_n && (cnt_n == flen_n);
	assign q_job = cap_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q <= 1'b0;
			cnt_q <= '0;
			lk_q <= 1'b0;
			flen_q <= '0;
			cap_q <= '0;
		end else if (acc) begin
			ok_q <= ok_n;
			cnt_q <= cnt_n;
			lk_q <= lk_n;
			flen_q <= flen_n;
			cap_q <= cap_n;
		end
	end

endmodule

@@ src/rfca_queue.sv @@
module rfca_queue
	import rfca_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  resp_job_t wr_job,
	output logic      full,
	input  logic      pop,
	output logic      nonempty,
	output resp_job_t rd_job
);

	resp_job_t         mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign full = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && nonempty;
	assign rd_job = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ src/rfca_back.sv @@
module rfca_back
	import rfca_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_nonempty,
	input  resp_job_t  q_job,
	output logic       q_pop,
	rfca_out_if.source tx
);

	resp_job_t        job_q;
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      sum_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;
	logic             load, last_load;
	logic [7:0]       body_byte, next_byte;

	assign load = busy_q && (!out_valid_q || tx.ready);
	assign last_load = load && (idx_q == IDX_LAST);
	assign q_pop = q_nonempty && (!busy_q || last_load);

	assign body_byte = resp_byte(job_q, idx_q);

	always_comb begin
		if (idx_q == IDX_CSUM_HI) next_byte = sum_q[15:8];
		else if (idx_q == IDX_LAST) next_byte = sum_q[7:0];
		else next_byte = body_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (last_load) begin
				busy_q <= 1'b0;
			end else if (load) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load) out_valid_q <= 1'b1;
			else if (tx.ready) out_valid_q <= 1'b0;
		end
	end

	// payload side: job, running checksum, output byte
	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
			sum_q <= '0;
		end else if (load && idx_q < IDX_CSUM_HI) begin
			sum_q <= sum_q + {8'h00, body_byte};
		end
		if (load) begin
			out_byte_q <= next_byte;
			out_last_q <= (idx_q == IDX_LAST);
		end
	end

	assign tx.valid = out_valid_q;
	assign tx.tx_byte = out_byte_q;
	assign tx.tx_last = out_last_q;

endmodule

@@ src/rdm_frame_check_and_ack.sv @@
// RDM request checker and responder. Request bytes enter on rx one per cycle
// while rx is ready; frame_start marks the first byte after a break. A frame
// with start code CC, sub-start code 01 and a frame length (message length plus
// two) of at least five answers, when its last byte arrives, with a 26-byte ACK
// to GET SUPPORTED_PARAMETERS on tx, UIDs swapped, transaction number echoed and
// the additive checksum last (tx_last set on its low byte). The response leaves
// at one byte per cycle while tx is ready, once the job has passed through the
// queue, the sender's job register and its output byte register.
// Up to four answers wait in a queue between the parser and the sender; rx
// ready drops only while that queue is full.
module rdm_frame_check_and_ack
	import rfca_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	rfca_in_if.sink    rx,
	rfca_out_if.source tx
);

	logic      q_push, q_full, q_pop, q_nonempty;
	resp_job_t q_wr_job, q_rd_job;

	rfca_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (q_wr_job)
	);

	rfca_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_job   (q_wr_job),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rd_job   (q_rd_job)
	);

	rfca_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_job      (q_rd_job),
		.q_pop      (q_pop),
		.tx         (tx)
	);

endmodule
